// File: rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the binary insertion sorter: default sizes,
// controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Width of the value fields on the channels.
  localparam int FIELD_BITS = 32;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_PROBE,
    ST_SHIFT,
    ST_INSERT,
    ST_DRAIN
  } bis_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new item, start the search window
    logic drop;        // store is full: record the overflow
    logic probe_rd;    // read the midpoint of the search window
    logic probe_upd;   // narrow the window with the read entry
    logic shift_step;  // move one entry up one place
    logic insert;      // write the item into the gap
    logic drain;       // stream the sorted set out
  } bis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;        // store holds CAPACITY entries
    logic last;        // captured item ends the set
    logic search_open; // search window is not empty
    logic shift_open;  // entries remain to move up
    logic drain_done;  // final result handed to the output register
  } bis_status_t;

endpackage

// File: rtl/bis_if.sv
// ----------------------------------------------------------------------------
// bis_in_if / bis_out_if
// Valid/ready channels of the binary insertion sorter. A transaction takes
// place at a rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bis_in_if;
  import bis_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [FIELD_BITS-1:0]  value;
  logic                          last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface bis_out_if;
  import bis_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [FIELD_BITS-1:0]  sorted_value;
  logic                          last_out;
  logic                          items_dropped;

  modport source (output valid, output sorted_value, output last_out,
                  output items_dropped, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input items_dropped, output ready);
endinterface

// File: rtl/bis_ram.sv
// ----------------------------------------------------------------------------
// bis_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bis_ctrl.sv
// ----------------------------------------------------------------------------
// bis_ctrl
// Controller of the binary insertion sorter: sequences the full-store check, the search,
// the shift, the insert and the output of a finished set.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bis_pkg::bis_status_t st,
  output bis_pkg::bis_cmd_t    cmd
);
  import bis_pkg::*;

  bis_state_t state;
  bis_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.full) begin
          cmd.drop   = 1'b1;
          state_next = st.last ? ST_DRAIN : ST_IDLE;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (st.search_open) begin
          cmd.probe_rd = 1'b1;
          state_next   = ST_PROBE;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_PROBE: begin
        cmd.probe_upd = 1'b1;
        state_next    = ST_SEARCH;
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (!st.shift_open) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = st.last ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        cmd.drain = 1'b1;
        if (st.drain_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/bis_dp.sv
// ----------------------------------------------------------------------------
// bis_dp
// Datapath of the binary insertion sorter: item and window registers, the
// sorted store, the shift pipeline and the output register.
// ----------------------------------------------------------------------------
module bis_dp #(
  parameter int CAPACITY   = bis_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bis_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,
  input  logic signed [bis_pkg::FIELD_BITS-1:0] in_value,
  input  logic                                  in_last_item,
  input  bis_pkg::bis_cmd_t                     cmd,
  output bis_pkg::bis_status_t                  st,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bis_pkg::FIELD_BITS-1:0] out_sorted_value,
  output logic                                  out_last_out,
  output logic                                  out_items_dropped
);
  import bis_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  logic                  descending;
  logic [VALUE_BITS-1:0] item;
  logic                  last;
  logic [CNT_W-1:0]      count;
  logic                  overflow;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      hi;
  logic [CNT_W-1:0]      mid_q;
  logic [CNT_W-1:0]      idx;
  logic                  pend;
  logic [ADDR_W-1:0]     pend_addr;
  logic [CNT_W-1:0]      rd_idx;
  logic                  rd_pend;
  logic                  rd_last;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic [CNT_W-1:0]                 mid;
  logic [CNT_W-1:0]                 idx_dec;
  logic                             entry_after;
  logic                             out_load;
  logic                             out_issue;
  logic [VALUE_BITS+FIELD_BITS-1:0] in_ext;
  logic [FIELD_BITS+VALUE_BITS-1:0] rd_ext;

  assign in_ext  = {{VALUE_BITS{in_value[FIELD_BITS-1]}}, in_value};
  assign rd_ext  = {{FIELD_BITS{ram_rdata[VALUE_BITS-1]}}, ram_rdata};
  assign mid     = lo + ((hi - lo) >> 1);
  assign idx_dec = idx - CNT_W'(1);

  // The read entry sorts strictly after the item.
  assign entry_after = descending ? ($signed(ram_rdata) < $signed(item))
                                  : ($signed(ram_rdata) > $signed(item));

  assign out_load  = cmd.drain && rd_pend && (!out_valid || out_ready);
  assign out_issue = cmd.drain && (rd_idx < count) && (!rd_pend || out_load);

  assign st.full        = (count == CNT_W'(CAPACITY));
  assign st.last        = last;
  assign st.search_open = (lo < hi);
  assign st.shift_open  = (idx > lo);
  assign st.drain_done  = cmd.drain && (rd_idx == count) && (!rd_pend || out_load);

  // Store port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = mid[ADDR_W-1:0];
    if (cmd.probe_rd) begin
      ram_re = 1'b1;
    end
    if (cmd.shift_step) begin
      ram_we    = pend;
      ram_re    = st.shift_open;
      ram_raddr = idx_dec[ADDR_W-1:0];
    end
    if (cmd.insert) begin
      ram_we    = 1'b1;
      ram_waddr = lo[ADDR_W-1:0];
      ram_wdata = item;
    end
    if (out_issue) begin
      ram_re    = 1'b1;
      ram_raddr = rd_idx[ADDR_W-1:0];
    end
  end

  bis_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_ext[VALUE_BITS-1:0];
      last <= in_last_item;
      lo   <= '0;
      hi   <= count;
      idx  <= count;
    end
    if (cmd.probe_rd) begin
      mid_q <= mid;
    end
    if (cmd.probe_upd) begin
      if (entry_after) begin
        hi <= mid_q;
      end else begin
        lo <= mid_q + CNT_W'(1);
      end
    end
    if (cmd.shift_step && st.shift_open) begin
      pend_addr <= idx[ADDR_W-1:0];
      idx       <= idx_dec;
    end
    if (out_issue) begin
      rd_last <= (rd_idx == count - CNT_W'(1));
    end
    if (out_load) begin
      out_sorted_value  <= rd_ext[FIELD_BITS-1:0];
      out_last_out      <= rd_last;
      out_items_dropped <= overflow;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
      count      <= '0;
      overflow   <= 1'b0;
      pend       <= 1'b0;
      rd_idx     <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        descending <= cfg_wdata;
      end
      if (cmd.drop) begin
        overflow <= 1'b1;
      end
      if (cmd.shift_step) begin
        pend <= st.shift_open;
      end
      if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
      if (out_issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (cmd.drain) begin
        rd_pend <= out_issue || (rd_pend && !out_load);
      end
      if (st.drain_done) begin
        count    <= '0;
        overflow <= 1'b0;
        rd_idx   <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/binary_insertion_sorter.sv
// Sequence: after its transaction an inserted item keeps the input busy through the check,
//   P binary search probes (at most 6 at the default capacity), the move up by one place
//   of the stored entries that sort after it, and the insert; a dropped item only the check.
// Each probe takes a registered store read and a window update, each moved entry a store read;
//   a set marked last streams out at one result per cycle while out_ready is high.
// Reset: synchronous, active high; empties the store, clears overflow and mode.
// ----------------------------------------------------------------------------
// binary_insertion_sorter
// Sorts signed items by binary insertion into a sorted store and streams the
// whole set out in order when an item marked last arrives.
// ----------------------------------------------------------------------------
module binary_insertion_sorter #(
  parameter int CAPACITY   = bis_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bis_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // Mode register: 0 ascending, 1 descending (signed order).
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  bis_in_if.sink     in_ch,
  bis_out_if.source  out_ch
);
  import bis_pkg::*;

  // The controller and the datapath talk only through these two bundles.
  bis_cmd_t    cmd;
  bis_status_t st;

  // The controller owns the input handshake. It takes a new transaction only
  // when the previous item is fully inserted or dropped, or when the previous set has
  // been handed completely to the output register. A result still waiting in
  // that register does not hold up the next input transaction.
  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the store, the search window (lo, hi), the shift
  // pointer and the output register. An item that finds the store full is
  // dropped and marks every result of its set with items_dropped. Equal
  // values keep their arrival order because the search stops at the first
  // entry that sorts strictly after the new item.
  bis_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_value          (in_ch.value),
    .in_last_item      (in_ch.last_item),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_sorted_value  (out_ch.sorted_value),
    .out_last_out      (out_ch.last_out),
    .out_items_dropped (out_ch.items_dropped)
  );

endmodule
